/* src/cpse_pkg.sv */
// ----------------------------------------------------------------------------
// cpse_pkg: shared types and constants for the PGN signal extractor
// Symbol codes, register map, value formats, datapath widths and the
// control structs that pass between the extractor's modules.
// ----------------------------------------------------------------------------
package cpse_pkg;

	// field widths
	localparam int KIND_W   = 2;
	localparam int DATA_W   = 18;
	localparam int TIME_W   = 63;
	localparam int VALUE_W  = 48;
	localparam int PGN_W    = 18;
	localparam int POS_W    = 6;
	localparam int FMT_W    = 2;
	localparam int SCALE_W  = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;

	localparam int PAYLOAD_BITS_DEF = 64;

	// datapath widths
	localparam int FIELD_W  = 17;              // extracted value, signed
	localparam int AMAG_W   = 16;              // |field|
	localparam int BMAG_W   = 32;              // |scale_factor|
	localparam int FRAC_W   = 32;              // dividend pre-shift (2^32)
	localparam int MAG_W    = AMAG_W + FRAC_W; // result magnitude
	localparam int STEP_W   = 6;
	localparam int MUL_STEPS = AMAG_W;
	localparam int DIV_STEPS = MAG_W;
	localparam int SUM_W    = VALUE_W + 2;

	// symbol kinds
	localparam logic [KIND_W-1:0] KIND_PGN      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PRIORITY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_PGN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_POSITION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_FORMAT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_VALUE = 3'd5;

	// value formats
	localparam logic [FMT_W-1:0] FMT_U16 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_U8  = 2'd2;
	localparam logic [FMT_W-1:0] FMT_S8  = 2'd3;

	// scale modes
	localparam logic MODE_MUL = 1'b0;
	localparam logic MODE_DIV = 1'b1;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;
	localparam logic [VALUE_W-1:0] VALUE_MAX   = 48'h7FFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] VALUE_MIN   = 48'h8000_0000_0000;

	typedef struct packed {
		logic [PGN_W-1:0]   target_pgn;
		logic [POS_W-1:0]   bit_position;
		logic [FMT_W-1:0]   value_format;
		logic               scale_mode;
		logic [SCALE_W-1:0] scale_factor;
		logic [VALUE_W-1:0] offset_value;
	} cfg_t;

	typedef struct packed {
		logic               close;      // priority symbol ends a matched frame
		logic [FIELD_W-1:0] field;      // extracted value, two's complement
		logic [TIME_W-1:0]  frame_time;
	} frame_t;

	typedef struct packed {
		logic              start;
		logic              op_div;
		logic [AMAG_W-1:0] a_mag;
		logic [BMAG_W-1:0] b_mag;
	} unit_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_HOLD
	} state_t;

endpackage

/* src/cpse_chan_if.sv */
// ----------------------------------------------------------------------------
// cpse channels: valid/ready interfaces for symbols in and samples out
// One transaction moves at a clock edge where valid and ready are high.
// ----------------------------------------------------------------------------
interface cpse_sym_if;
	logic                              valid;
	logic                              ready;
	logic [cpse_pkg::KIND_W-1:0]       symbol_kind;
	logic [cpse_pkg::DATA_W-1:0]       symbol_data;
	logic [cpse_pkg::TIME_W-1:0]       symbol_time;

	modport source (output valid, symbol_kind, symbol_data, symbol_time, input ready);
	modport sink   (input valid, symbol_kind, symbol_data, symbol_time, output ready);
endinterface

interface cpse_sample_if;
	logic                              valid;
	logic                              ready;
	logic [cpse_pkg::TIME_W-1:0]       sample_time;
	logic signed [cpse_pkg::VALUE_W-1:0] sample_value;

	modport source (output valid, sample_time, sample_value, input ready);
	modport sink   (input valid, sample_time, sample_value, output ready);
endinterface

/* src/cpse_frame.sv */
// ----------------------------------------------------------------------------
// cpse_frame: frame tracker and payload register
// Follows PGN / data / priority symbols, shifts data bytes into the
// payload and extracts the configured field when a frame closes.
// ----------------------------------------------------------------------------
module cpse_frame #(
	parameter int PAYLOAD_BITS = cpse_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [cpse_pkg::KIND_W-1:0]   kind,
	input  logic [cpse_pkg::DATA_W-1:0]   data,
	input  logic [cpse_pkg::TIME_W-1:0]   stamp,
	input  cpse_pkg::cfg_t                cfg,
	output cpse_pkg::frame_t              frm
);

	logic                          in_phase_q;
	logic [cpse_pkg::TIME_W-1:0]   frame_time_q;
	logic [PAYLOAD_BITS-1:0]       payload_q;
	logic [PAYLOAD_BITS-1:0]       shifted;
	logic [15:0]                   low16;
	logic                          match;

	assign match = accept && !in_phase_q && (kind == cpse_pkg::KIND_PGN)
		&& (data == cfg.target_pgn);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_phase_q <= 1'b0;
		end else if (accept) begin
			if (kind == cpse_pkg::KIND_PRIORITY) begin
				in_phase_q <= 1'b0;
			end else if (match) begin
				in_phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			frame_time_q <= stamp;
			payload_q    <= '0;
		end else if (accept && in_phase_q && kind == cpse_pkg::KIND_DATA) begin
			payload_q <= {payload_q[PAYLOAD_BITS-9:0], data[7:0]};
		end
	end

	// bits above the payload read as zero
	assign shifted = payload_q >> cfg.bit_position;
	assign low16   = shifted[15:0];

	always_comb begin
		frm.close      = accept && in_phase_q && (kind == cpse_pkg::KIND_PRIORITY);
		frm.frame_time = frame_time_q;
		unique case (cfg.value_format)
			cpse_pkg::FMT_U16: frm.field = {1'b0, low16};
			cpse_pkg::FMT_S16: frm.field = {low16[15], low16};
			cpse_pkg::FMT_U8:  frm.field = {9'd0, low16[7:0]};
			default:           frm.field = {{9{low16[7]}}, low16[7:0]};
		endcase
	end

endmodule

/* src/cpse_mag_unit.sv */
// ----------------------------------------------------------------------------
// cpse_mag_unit: serial multiply / divide on magnitudes
// One 49-bit adder does shift-add multiply (16 steps) or restoring
// division of |a| * 2^32 by |b| (48 steps), one bit per cycle.
// ----------------------------------------------------------------------------
module cpse_mag_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpse_pkg::unit_req_t           req,
	output logic                          done,
	output logic [cpse_pkg::MAG_W-1:0]    mag
);

	localparam int AW = cpse_pkg::MAG_W + 1;
	localparam int RW = cpse_pkg::BMAG_W;

	logic                          busy_q;
	logic                          done_q;
	logic [cpse_pkg::STEP_W-1:0]   cnt_q;
	logic                          div_q;
	logic [cpse_pkg::MAG_W-1:0]    dvd_q;   // multiplier / dividend bits, MSB first
	logic [cpse_pkg::MAG_W-1:0]    acc_q;   // product or quotient
	logic [RW-1:0]                 rem_q;
	logic [cpse_pkg::BMAG_W-1:0]   b_q;

	logic [RW:0]                   rem_shift;
	logic [AW-1:0]                 add_x;
	logic [AW-1:0]                 add_y;
	logic [AW-1:0]                 sum;
	logic                          fits;

	assign rem_shift = {rem_q, dvd_q[cpse_pkg::MAG_W-1]};

	always_comb begin
		if (div_q) begin
			add_x = {{(AW-RW-1){1'b0}}, rem_shift};
			add_y = ~{{(AW-cpse_pkg::BMAG_W){1'b0}}, b_q};
		end else begin
			add_x = {1'b0, acc_q[cpse_pkg::MAG_W-2:0], 1'b0};
			add_y = dvd_q[cpse_pkg::MAG_W-1] ? {{(AW-cpse_pkg::BMAG_W){1'b0}}, b_q} : '0;
		end
		sum  = add_x + add_y + {{(AW-1){1'b0}}, div_q};
		fits = !sum[AW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.op_div ? cpse_pkg::STEP_W'(cpse_pkg::DIV_STEPS - 1)
				                     : cpse_pkg::STEP_W'(cpse_pkg::MUL_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.op_div;
			b_q   <= req.b_mag;
			dvd_q <= {req.a_mag, {cpse_pkg::FRAC_W{1'b0}}};
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[cpse_pkg::MAG_W-2:0], 1'b0};
			if (div_q) begin
				rem_q <= fits ? sum[RW-1:0] : rem_shift[RW-1:0];
				acc_q <= {acc_q[cpse_pkg::MAG_W-2:0], fits};
			end else begin
				acc_q <= sum[cpse_pkg::MAG_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign mag  = acc_q;

endmodule

/* src/can_pgn_signal_extractor.sv */
// ----------------------------------------------------------------------------
// can_pgn_signal_extractor: J1939 PGN signal extractor
// Decodes one field of a chosen PGN from a PDU symbol stream and emits
// it scaled and offset in Q31.16 with the frame's timestamp.
// ----------------------------------------------------------------------------
// Usage: symbols that do not close a frame (PGN, data byte, other) are taken
// one per cycle. A priority symbol that closes a matched frame starts the
// serial multiply/divide unit, and the symbol input stays not ready until the
// sample has been placed in the output register. In between, in order: the
// closing symbol, the steps of the one-bit-per-cycle shared adder (16 steps
// to multiply, 48 to divide), the done flag, then the offset add and
// saturation into the output register, which waits while a stalled sink
// still holds the previous sample. The output register lets the next symbols
// flow while a sample waits to be taken. Configuration writes go through
// cfg_we / cfg_index / cfg_wdata and take effect on the next cycle; write
// only while idle.
// ----------------------------------------------------------------------------
module can_pgn_signal_extractor #(
	parameter int PAYLOAD_BITS = cpse_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	cpse_sym_if.sink                           sym,
	cpse_sample_if.source                      sample,
	input  logic                               cfg_we,
	input  logic [cpse_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cpse_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	// configuration registers
	cpse_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_pgn   <= '0;
			cfg_q.bit_position <= '0;
			cfg_q.value_format <= cpse_pkg::FMT_U16;
			cfg_q.scale_mode   <= cpse_pkg::MODE_MUL;
			cfg_q.scale_factor <= cpse_pkg::SCALE_RESET;
			cfg_q.offset_value <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpse_pkg::REG_TARGET_PGN:   cfg_q.target_pgn   <= cfg_wdata[cpse_pkg::PGN_W-1:0];
				cpse_pkg::REG_BIT_POSITION: cfg_q.bit_position <= cfg_wdata[cpse_pkg::POS_W-1:0];
				cpse_pkg::REG_VALUE_FORMAT: cfg_q.value_format <= cfg_wdata[cpse_pkg::FMT_W-1:0];
				cpse_pkg::REG_SCALE_MODE:   cfg_q.scale_mode   <= cfg_wdata[0];
				cpse_pkg::REG_SCALE_FACTOR: cfg_q.scale_factor <= cfg_wdata[cpse_pkg::SCALE_W-1:0];
				cpse_pkg::REG_OFFSET_VALUE: cfg_q.offset_value <= cfg_wdata[cpse_pkg::VALUE_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// sequencer
	cpse_pkg::state_t state_q, state_d;
	logic sym_accept;
	logic unit_done;
	logic load_out;

	cpse_pkg::frame_t    frm;
	cpse_pkg::unit_req_t req;
	logic [cpse_pkg::MAG_W-1:0] mag;

	assign sym_accept = sym.valid && sym.ready;

	cpse_frame #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (sym_accept),
		.kind   (sym.symbol_kind),
		.data   (sym.symbol_data),
		.stamp  (sym.symbol_time),
		.cfg    (cfg_q),
		.frm    (frm)
	);

	// operand magnitudes, taken when a matched frame closes
	logic [cpse_pkg::FIELD_W-1:0] v_abs;
	logic [cpse_pkg::SCALE_W-1:0] s_abs;

	always_comb begin
		v_abs = frm.field[cpse_pkg::FIELD_W-1] ? (~frm.field + 1'b1) : frm.field;
		s_abs = cfg_q.scale_factor[cpse_pkg::SCALE_W-1]
			? (~cfg_q.scale_factor + 1'b1) : cfg_q.scale_factor;
		req.start  = frm.close;
		req.op_div = cfg_q.scale_mode == cpse_pkg::MODE_DIV;
		req.a_mag  = v_abs[cpse_pkg::AMAG_W-1:0];
		req.b_mag  = s_abs;
	end

	cpse_mag_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (unit_done),
		.mag    (mag)
	);

	// sign and special-case flags for the finishing step
	logic neg_q, vneg_q, vzero_q, divzero_q;

	always_ff @(posedge clk) begin
		if (frm.close) begin
			neg_q     <= frm.field[cpse_pkg::FIELD_W-1] ^ cfg_q.scale_factor[cpse_pkg::SCALE_W-1];
			vneg_q    <= frm.field[cpse_pkg::FIELD_W-1];
			vzero_q   <= frm.field == '0;
			divzero_q <= (cfg_q.scale_mode == cpse_pkg::MODE_DIV) && (cfg_q.scale_factor == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpse_pkg::ST_IDLE: if (frm.close) state_d = cpse_pkg::ST_CALC;
			cpse_pkg::ST_CALC: if (unit_done) state_d = cpse_pkg::ST_HOLD;
			cpse_pkg::ST_HOLD: if (load_out)  state_d = cpse_pkg::ST_IDLE;
			default:           state_d = cpse_pkg::ST_IDLE;
		endcase
	end

	logic out_valid_q;

	always_comb begin
		sym.ready = state_q == cpse_pkg::ST_IDLE;
		load_out  = (state_q == cpse_pkg::ST_HOLD) && (!out_valid_q || sample.ready);
	end

	// apply sign, add offset, saturate to Q31.16
	logic [cpse_pkg::SUM_W-1:0]   q_ext;
	logic [cpse_pkg::SUM_W-1:0]   sum;
	logic [cpse_pkg::VALUE_W-1:0] result;

	always_comb begin
		q_ext = {2'b00, mag};
		if (neg_q) begin
			q_ext = ~q_ext + 1'b1;
		end
		sum = q_ext + {{2{cfg_q.offset_value[cpse_pkg::VALUE_W-1]}}, cfg_q.offset_value};
		priority if (divzero_q) begin
			// divide by zero: saturate by the field's sign, offset ignored
			if (vzero_q) begin
				result = '0;
			end else begin
				result = vneg_q ? cpse_pkg::VALUE_MIN : cpse_pkg::VALUE_MAX;
			end
		end else if (sum[cpse_pkg::SUM_W-1:cpse_pkg::VALUE_W-1] == '0
			|| sum[cpse_pkg::SUM_W-1:cpse_pkg::VALUE_W-1] == '1) begin
			result = sum[cpse_pkg::VALUE_W-1:0];
		end else begin
			result = sum[cpse_pkg::SUM_W-1] ? cpse_pkg::VALUE_MIN : cpse_pkg::VALUE_MAX;
		end
	end

	// output register
	logic [cpse_pkg::TIME_W-1:0]  out_time_q;
	logic [cpse_pkg::VALUE_W-1:0] out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (sample.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_time_q  <= frm.frame_time;
			out_value_q <= result;
		end
	end

	assign sample.valid        = out_valid_q;
	assign sample.sample_time  = out_time_q;
	assign sample.sample_value = $signed(out_value_q);

endmodule

/* tb/can_pgn_signal_extractor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_pgn_signal_extractor_tb: self-checking bench for the PGN signal extractor
// Feeds J1939 PDU symbol streams through the symbol channel. An in-bench
// decoder tracks the frame state and works out each Q31.16 sample, and every
// sample transaction on the output channel is checked against it in order.
// Register settings change between phases while the block is drained.
// ----------------------------------------------------------------------------
module can_pgn_signal_extractor_tb;

	// clock period 20 ns; reset hold length in clock cycles
	localparam int unsigned RESET_CYCLES    = 11;
	// settle after the serial divide, which holds off the symbol input,
	// before reconfiguring
	localparam int unsigned SETTLE_CYCLES   = 64;
	// worst case per item: long sender gap + divide + longest receiver hold,
	// taken several times over
	localparam int unsigned CYCLE_LIMIT     = 4_000_000;
	localparam int unsigned NUM_PHASES      = 12;
	localparam int unsigned ITEMS_PER_PHASE = 155;

	// register indexes past the end of the map; writes there must do nothing
	localparam logic [cpse_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [cpse_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// saturation bounds of the 48-bit signed result
	localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic [cpse_pkg::KIND_W-1:0] kind;
		logic [cpse_pkg::DATA_W-1:0] data;
		logic [cpse_pkg::TIME_W-1:0] stamp;
	} symbol_t;

	typedef struct packed {
		logic [cpse_pkg::TIME_W-1:0]  stamp;
		logic [cpse_pkg::VALUE_W-1:0] value;
	} sample_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                            cfg_we;
	logic [cpse_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cpse_pkg::CFG_DATA_W-1:0] cfg_wdata;

	cpse_sym_if    sym_bus ();
	cpse_sample_if sample_bus ();

	can_pgn_signal_extractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym       (sym_bus),
		.sample    (sample_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Decoder state: a private copy of the register file and frame state.
	// Registers change only while drained, so they are updated at write time.
	// ------------------------------------------------------------------
	cpse_pkg::cfg_t active_cfg = '{
		target_pgn:   '0,
		bit_position: '0,
		value_format: cpse_pkg::FMT_U16,
		scale_mode:   cpse_pkg::MODE_MUL,
		scale_factor: cpse_pkg::SCALE_RESET,
		offset_value: '0
	};

	logic                        frame_open    = 1'b0;
	logic [cpse_pkg::TIME_W-1:0] frame_stamp   = '0;
	logic [63:0]                 frame_payload = '0;

	symbol_t symbol_backlog[$];   // symbols waiting to be driven
	sample_t samples_due[$];      // samples the block still owes us

	symbol_t     sym_cur;
	int unsigned tx_gap    = 0;
	int unsigned rx_gap    = 0;
	bit          tx_eager  = 1'b0;
	bit          rx_eager  = 1'b0;
	int unsigned samples_seen = 0;
	int unsigned mismatches   = 0;
	int unsigned cycles       = 0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly back-to-back, sometimes a few cycles, rarely a long gap
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 90);
	endfunction

	// Field extraction + Q16.16 scaling + offset, saturated to 48 bits.
	function automatic logic [cpse_pkg::VALUE_W-1:0] scaled_sample(logic [63:0] payload);
		logic [63:0] shifted;
		longint      field;
		longint      gain;
		longint      offs;
		longint      q;
		longint      sum;
		shifted = payload >> active_cfg.bit_position;
		case (active_cfg.value_format)
			cpse_pkg::FMT_U16: field = shifted[15:0];
			cpse_pkg::FMT_S16: field = $signed(shifted[15:0]);
			cpse_pkg::FMT_U8:  field = shifted[7:0];
			default:           field = $signed(shifted[7:0]);
		endcase
		gain = $signed(active_cfg.scale_factor);
		offs = $signed(active_cfg.offset_value);
		if (active_cfg.scale_mode == cpse_pkg::MODE_DIV) begin
			// divide by zero saturates by sign of the field, offset skipped
			if (gain == 0) begin
				if (field > 0)
					return cpse_pkg::VALUE_MAX;
				if (field < 0)
					return cpse_pkg::VALUE_MIN;
				return '0;
			end
			q = (field <<< 32) / gain;   // truncates toward zero
		end else begin
			q = field * gain;
		end
		sum = q + offs;
		if (sum > SAT_HI)
			return cpse_pkg::VALUE_MAX;
		if (sum < SAT_LO)
			return cpse_pkg::VALUE_MIN;
		return sum[cpse_pkg::VALUE_W-1:0];
	endfunction

	// One accepted symbol through the frame tracker.
	function automatic void decode_symbol(symbol_t s);
		if (!frame_open) begin
			if (s.kind == cpse_pkg::KIND_PGN && s.data == active_cfg.target_pgn) begin
				frame_open    = 1'b1;
				frame_stamp   = s.stamp;
				frame_payload = '0;
			end
		end else if (s.kind == cpse_pkg::KIND_DATA) begin
			// newest eight bytes, MSB first; upper symbol bits dropped
			frame_payload = {frame_payload[55:0], s.data[7:0]};
		end else if (s.kind == cpse_pkg::KIND_PRIORITY) begin
			samples_due.insert(samples_due.size(),
				'{stamp: frame_stamp, value: scaled_sample(frame_payload)});
		end
		// priority always drops back to idle, matched frame or not
		if (s.kind == cpse_pkg::KIND_PRIORITY)
			frame_open = 1'b0;
	endfunction

	function automatic void queue_symbol(logic [cpse_pkg::KIND_W-1:0] kind,
			logic [cpse_pkg::DATA_W-1:0] data, logic [cpse_pkg::TIME_W-1:0] stamp);
		symbol_backlog.insert(symbol_backlog.size(), '{kind: kind, data: data, stamp: stamp});
	endfunction

	// A frame with random content: PGN (mostly the target), 0..10 data bytes with
	// the odd stray symbol in between, then usually a closing priority. Now and
	// then just one noise symbol instead. Returns the frame symbols queued.
	function automatic int unsigned queue_frame(cpse_pkg::cfg_t c);
		int unsigned n;
		int unsigned nbytes;
		logic [63:0] w;
		logic [63:0] t;
		n = 0;
		w = rand64();
		t = rand64();
		if ($urandom_range(0, 99) < 8) begin
			queue_symbol(w[1:0], w[19:2], t[62:0]);
			return 0;
		end
		queue_symbol(cpse_pkg::KIND_PGN,
			($urandom_range(0, 4) == 0) ? w[cpse_pkg::DATA_W-1:0] : c.target_pgn, t[62:0]);
		n++;
		nbytes = $urandom_range(0, 10);
		repeat (nbytes) begin
			w = rand64();
			t = rand64();
			if (w[63:60] == 4'h0) begin
				// stray PGN (maybe the target) or other symbol inside the frame
				queue_symbol(w[59] ? cpse_pkg::KIND_OTHER : cpse_pkg::KIND_PGN,
					w[58] ? c.target_pgn : w[cpse_pkg::DATA_W+19:20], t[62:0]);
				n++;
			end
			queue_symbol(cpse_pkg::KIND_DATA, w[cpse_pkg::DATA_W-1:0], t[62:0]);
			n++;
		end
		// one in ten left open: the next frame's PGN lands in the data phase
		if ($urandom_range(0, 9) != 0) begin
			t = rand64();
			queue_symbol(cpse_pkg::KIND_PRIORITY, w[cpse_pkg::DATA_W+39:40], t[62:0]);
			n++;
		end
		return n;
	endfunction

	// Per-phase settings; the first few pin extremes and special cases.
	function automatic cpse_pkg::cfg_t pick_config(int unsigned phase);
		cpse_pkg::cfg_t c;
		logic [63:0]    a;
		logic [63:0]    b;
		a = rand64();
		b = rand64();
		c.target_pgn   = a[cpse_pkg::PGN_W-1:0];
		c.bit_position = ($urandom_range(0, 3) == 0) ? a[23:18]
			: cpse_pkg::POS_W'($urandom_range(0, 40));
		c.value_format = a[25:24];
		c.scale_mode   = a[26];
		case ($urandom_range(0, 3))
			0: c.scale_factor = b[31:0];
			1: c.scale_factor = cpse_pkg::SCALE_RESET;
			2: c.scale_factor = {{14{b[17]}}, b[17:0]};   // within about +/-2.0
			default: c.scale_factor = {{24{b[7]}}, b[7:0]};  // tiny: divides blow up
		endcase
		c.offset_value = a[27] ? b[63:16] : {{28{b[63]}}, b[63:44]};
		case (phase)
			0: begin
				// largest gain and offset: saturates high
				c.target_pgn   = '1;
				c.bit_position = '0;
				c.value_format = cpse_pkg::FMT_U16;
				c.scale_mode   = cpse_pkg::MODE_MUL;
				c.scale_factor = 32'h7FFF_FFFF;
				c.offset_value = cpse_pkg::VALUE_MAX;
			end
			1: begin
				// divide by zero, signed field: both signs and zero
				c.scale_mode   = cpse_pkg::MODE_DIV;
				c.scale_factor = '0;
				c.value_format = cpse_pkg::FMT_S16;
			end
			2: begin
				// shift to the top bit, most negative gain and offset
				c.target_pgn   = '0;
				c.bit_position = '1;
				c.value_format = cpse_pkg::FMT_S8;
				c.scale_mode   = cpse_pkg::MODE_MUL;
				c.scale_factor = 32'h8000_0000;
				c.offset_value = cpse_pkg::VALUE_MIN;
			end
			3: begin
				c.scale_mode   = cpse_pkg::MODE_DIV;
				c.scale_factor = 32'd1;
				c.value_format = cpse_pkg::FMT_U16;
				c.offset_value = '0;
			end
			4: begin
				c.scale_mode   = cpse_pkg::MODE_DIV;
				c.scale_factor = '1;
				c.value_format = cpse_pkg::FMT_S16;
				c.offset_value = cpse_pkg::VALUE_MAX;
			end
			5: begin
				c.scale_mode   = cpse_pkg::MODE_DIV;
				c.scale_factor = 32'h8000_0000;
				c.value_format = cpse_pkg::FMT_S16;
				c.offset_value = cpse_pkg::VALUE_MIN;
			end
			6: begin
				c.scale_mode   = cpse_pkg::MODE_MUL;
				c.scale_factor = 32'h8000_0000;
				c.value_format = cpse_pkg::FMT_S16;
				c.offset_value = cpse_pkg::VALUE_MIN;
			end
			default: ;
		endcase
		return c;
	endfunction

	// One register write per clock; cfg_we is dropped by the caller.
	task automatic cfg_write(logic [cpse_pkg::CFG_IDX_W-1:0] idx,
			logic [cpse_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			cpse_pkg::REG_TARGET_PGN:
				active_cfg.target_pgn   = val[cpse_pkg::PGN_W-1:0];
			cpse_pkg::REG_BIT_POSITION:
				active_cfg.bit_position = val[cpse_pkg::POS_W-1:0];
			cpse_pkg::REG_VALUE_FORMAT:
				active_cfg.value_format = val[cpse_pkg::FMT_W-1:0];
			cpse_pkg::REG_SCALE_MODE:
				active_cfg.scale_mode   = val[0];
			cpse_pkg::REG_SCALE_FACTOR:
				active_cfg.scale_factor = val[cpse_pkg::SCALE_W-1:0];
			cpse_pkg::REG_OFFSET_VALUE:
				active_cfg.offset_value = val[cpse_pkg::VALUE_W-1:0];
			default: ;
		endcase
	endtask

	// Whole register set; unused upper write bits carry junk, which must be
	// dropped. Spare indexes get a write too.
	task automatic load_config(cpse_pkg::cfg_t c);
		logic [63:0] j;
		j = rand64();
		cfg_write(cpse_pkg::REG_TARGET_PGN,
			{j[cpse_pkg::CFG_DATA_W-1:cpse_pkg::PGN_W], c.target_pgn});
		cfg_write(cpse_pkg::REG_BIT_POSITION,
			{j[cpse_pkg::CFG_DATA_W-1:cpse_pkg::POS_W], c.bit_position});
		cfg_write(cpse_pkg::REG_VALUE_FORMAT,
			{j[cpse_pkg::CFG_DATA_W-1:cpse_pkg::FMT_W], c.value_format});
		cfg_write(cpse_pkg::REG_SCALE_MODE,
			{j[cpse_pkg::CFG_DATA_W-1:1], c.scale_mode});
		cfg_write(cpse_pkg::REG_SCALE_FACTOR,
			{j[cpse_pkg::CFG_DATA_W-1:cpse_pkg::SCALE_W], c.scale_factor});
		cfg_write(cpse_pkg::REG_OFFSET_VALUE, c.offset_value);
		j = rand64();
		cfg_write(REG_SPARE_LO, j[cpse_pkg::CFG_DATA_W-1:0]);
		cfg_write(REG_SPARE_HI, j[63:16]);
		@(posedge clk);
		cfg_we <= 1'b0;
		// start queueing away from the clock edge
		@(negedge clk);
	endtask

	// Sender holds back until every owed sample is in, then lets the
	// multiply/divide unit settle.
	task automatic wait_drained();
		while (symbol_backlog.size() != 0 || sym_bus.valid || samples_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Symbol driver: predicts on every accepted transaction, then offers
	// the next symbol after a random gap. valid holds until ready.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			sym_bus.valid <= 1'b0;
		end else begin
			if ($urandom_range(0, 399) == 0)
				tx_eager = !tx_eager;
			if (sym_bus.valid && sym_bus.ready)
				decode_symbol(sym_cur);
			if (!sym_bus.valid || sym_bus.ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					sym_bus.valid <= 1'b0;
				end else if (symbol_backlog.size() > 0) begin
					sym_cur = symbol_backlog.pop_front();
					sym_bus.symbol_kind <= sym_cur.kind;
					sym_bus.symbol_data <= sym_cur.data;
					sym_bus.symbol_time <= sym_cur.stamp;
					sym_bus.valid       <= 1'b1;
					tx_gap = tx_eager ? 0 : idle_gap();
				end else begin
					sym_bus.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample monitor: checks each accepted transaction against the oldest
	// owed sample and throttles ready. Every 96 samples (first at 40) it
	// holds ready low so the output register fills and the block backs up
	// onto the symbol input.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sample_t due;
		if (!arst_n) begin
			sample_bus.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 399) == 0)
				rx_eager = !rx_eager;
			if (sample_bus.valid && sample_bus.ready) begin
				if (samples_due.size() == 0) begin
					$error("sample with nothing owed: sample_time %0d sample_value %0d",
						sample_bus.sample_time, sample_bus.sample_value);
					mismatches++;
				end else begin
					due = samples_due.pop_front();
					if (sample_bus.sample_time !== due.stamp) begin
						$error("sample_time mismatch: expected %0d, actual %0d",
							due.stamp, sample_bus.sample_time);
						mismatches++;
					end
					if (sample_bus.sample_value !== due.value) begin
						$error("sample_value mismatch: expected %0d, actual %0d",
							$signed(due.value), sample_bus.sample_value);
						mismatches++;
					end
				end
				samples_seen++;
				if (samples_seen % 96 == 40)
					rx_gap = $urandom_range(300, 500);
			end
			if (rx_gap > 0) begin
				rx_gap--;
				sample_bus.ready <= 1'b0;
			end else begin
				sample_bus.ready <= 1'b1;
				rx_gap = rx_eager ? 0 : idle_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus: directed frames at reset settings, then phases of random
	// frames, each with its own register set.
	// ------------------------------------------------------------------
	initial begin
		int unsigned    phase_items;
		cpse_pkg::cfg_t c;

		sym_bus.valid       = 1'b0;
		sym_bus.symbol_kind = cpse_pkg::KIND_OTHER;
		sym_bus.symbol_data = '0;
		sym_bus.symbol_time = '0;
		sample_bus.ready    = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle: priority, data, other and a non-matching PGN change nothing
		queue_symbol(cpse_pkg::KIND_PRIORITY, 18'h3FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
		queue_symbol(cpse_pkg::KIND_DATA,     18'h3FFFF, 63'h0);
		queue_symbol(cpse_pkg::KIND_OTHER,    18'h3FFFF, 63'h5555_5555_5555_5555);
		queue_symbol(cpse_pkg::KIND_PGN,      18'h3FFFF, 63'h2AAA_AAAA_AAAA_AAAA);
		// target PGN (reset value 0) opens a frame at the latest time
		queue_symbol(cpse_pkg::KIND_PGN,      18'h00000, 63'h7FFF_FFFF_FFFF_FFFF);
		// PGN during the data phase is ignored, as is other
		queue_symbol(cpse_pkg::KIND_PGN,      18'h00000, 63'h0);
		// upper data bits must not reach the payload
		queue_symbol(cpse_pkg::KIND_DATA,     18'h3FF12, 63'h1);
		queue_symbol(cpse_pkg::KIND_OTHER,    18'h00000, 63'h2);
		queue_symbol(cpse_pkg::KIND_DATA,     18'h00000, 63'h3);
		// nine bytes in total: the oldest falls off the top
		queue_symbol(cpse_pkg::KIND_DATA,     18'h00080, 63'h4);
		queue_symbol(cpse_pkg::KIND_DATA,     18'h000FF, 63'h5);
		queue_symbol(cpse_pkg::KIND_DATA,     18'h00001, 63'h6);
		queue_symbol(cpse_pkg::KIND_DATA,     18'h0007F, 63'h7);
		queue_symbol(cpse_pkg::KIND_DATA,     18'h000A5, 63'h8);
		queue_symbol(cpse_pkg::KIND_DATA,     18'h2005A, 63'h9);
		queue_symbol(cpse_pkg::KIND_DATA,     18'h000C3, 63'hA);
		queue_symbol(cpse_pkg::KIND_PRIORITY, 18'h00000, 63'hB);
		// second priority while idle, then an empty frame at time zero
		queue_symbol(cpse_pkg::KIND_PRIORITY, 18'h00000, 63'hC);
		queue_symbol(cpse_pkg::KIND_PGN,      18'h00000, 63'h0);
		queue_symbol(cpse_pkg::KIND_PRIORITY, 18'h00000, 63'hD);
		wait_drained();

		for (int unsigned p = 0; p < NUM_PHASES; p++) begin
			c = pick_config(p);
			load_config(c);
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE)
				phase_items += queue_frame(c);
			// close any frame left open before the next register change
			queue_symbol(cpse_pkg::KIND_PRIORITY, '0, '0);
			wait_drained();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
